>>> rtl/core/btarb_pkg.sv
// Shared constants, codes and item types for the bakery ticket arbiter.
package btarb_pkg;

  localparam int THREADS     = 32;
  localparam int TICKET_BITS = 16;
  localparam int ID_W        = 5;
  localparam int IDX_W       = (THREADS > 1) ? $clog2(THREADS) : 1;

  typedef enum logic {
    CMD_REQ = 1'b0,
    CMD_REL = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_DUP        = 2'd1,
    STAT_NOT_HOLDER = 2'd2,
    STAT_SAT        = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic            command;
    logic [ID_W-1:0] src_id;
  } in_item_t;

  typedef struct packed {
    logic            grant_valid;
    logic [ID_W-1:0] grant_thread;
    logic            lock_busy;
    logic [1:0]      status;
  } out_item_t;

  typedef struct packed {
    logic [TICKET_BITS-1:0] ticket;
    logic                   waiting;
  } cell_t;

  typedef struct packed {
    logic                   tkt_en;
    logic [IDX_W-1:0]       tkt_idx;
    logic [TICKET_BITS-1:0] tkt_val;
    logic                   wait_en;
    logic [IDX_W-1:0]       wait_idx;
    logic                   wait_val;
  } ring_wr_t;

  typedef struct packed {
    logic                   tkt_we;
    logic [TICKET_BITS-1:0] tkt_val;
    logic                   wait_we;
    logic                   wait_val;
  } cell_wr_t;

endpackage

>>> rtl/core/btarb_cell.sv
// One ring cell holding the ticket and waiting bit of one thread slot.
module btarb_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  btarb_pkg::cell_t   prev_i,
  input  btarb_pkg::cell_wr_t wr_i,
  output btarb_pkg::cell_t   data_o
);

  btarb_pkg::cell_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (shift_i) begin
      data_d = prev_i;
    end else begin
      if (wr_i.tkt_we) begin
        data_d.ticket = wr_i.tkt_val;
      end
      if (wr_i.wait_we) begin
        data_d.waiting = wr_i.wait_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

>>> rtl/core/btarb_ring.sv
// Circular chain of ticket cells with a scan head and indexed writes at home position.
module btarb_ring (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  btarb_pkg::ring_wr_t wr_i,
  output btarb_pkg::cell_t    head_o
);

  btarb_pkg::cell_t    cells[btarb_pkg::THREADS];
  btarb_pkg::cell_wr_t wr[btarb_pkg::THREADS];

  for (genvar i = 0; i < btarb_pkg::THREADS; i++) begin : g_cell
    always_comb begin
      wr[i].tkt_we   = wr_i.tkt_en && (wr_i.tkt_idx == btarb_pkg::IDX_W'(i));
      wr[i].tkt_val  = wr_i.tkt_val;
      wr[i].wait_we  = wr_i.wait_en && (wr_i.wait_idx == btarb_pkg::IDX_W'(i));
      wr[i].wait_val = wr_i.wait_val;
    end

    btarb_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift_i),
      .prev_i (cells[(i + 1) % btarb_pkg::THREADS]),
      .wr_i   (wr[i]),
      .data_o (cells[i])
    );
  end

  assign head_o = cells[0];

endmodule

>>> rtl/core/bakery_ticket_arbiter_core.sv
// Top level of the bakery ticket arbiter: control, scan head and result register.
//
// The input channel (in_valid_i, in_ready_o, in_item_i) carries one command per
// item: a lock request or release from one thread id. The output channel
// (out_valid_o, out_ready_i, out_item_o) returns exactly one result item per
// command: grant flag, current holder, busy flag and status code.
// Tickets and waiting bits live in a ring of THREADS cells that rotates by one
// cell per cycle past a scan head, which finds the largest ticket, the waiting
// thread with the smallest (ticket, id) and the requester's waiting bit.
// The ring makes one full turn in the scan state; the state update is then made
// in the finish state with the ring back at home, and the result is written to
// the output register. A new item is accepted only in the idle state, after the
// finish state of the last one, so items are handled one at a time.
// Reset clears all tickets, waiting bits and the holder; the lock is free.
// A new item is taken while an earlier result still waits in the output
// register; if the receiver stalls, the update of the next item holds until
// that result has been taken.
module bakery_ticket_arbiter_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  btarb_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output btarb_pkg::out_item_t out_item_o
);

  localparam int IW = btarb_pkg::IDX_W;
  localparam int TB = btarb_pkg::TICKET_BITS;

  btarb_pkg::state_e state_q, state_d;

  logic                          cmd_q;
  logic [btarb_pkg::ID_W-1:0]    id_q;
  logic [IW-1:0]                 cnt_q;
  logic [TB-1:0]                 max_q, max_d;
  logic                          found_q, found_d;
  logic [IW-1:0]                 best_q, best_d;
  logic [TB-1:0]                 best_tkt_q, best_tkt_d;
  logic                          idwait_q, idwait_d;
  logic                          holder_v_q, holder_v_d;
  logic [IW-1:0]                 holder_q, holder_d;
  logic                          out_valid_q;
  btarb_pkg::out_item_t          out_q, out_d;

  logic                accept;
  logic                scan_en;
  logic                fin_fire;
  logic                last;
  btarb_pkg::cell_t    head;
  btarb_pkg::ring_wr_t wr;
  logic                in_range;
  logic                is_holder;

  btarb_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .shift_i(scan_en),
    .wr_i   (wr),
    .head_o (head)
  );

  assign accept   = in_valid_i && in_ready_o;
  assign last     = (cnt_q == IW'(btarb_pkg::THREADS - 1));
  assign fin_fire = (state_q == btarb_pkg::S_FINISH) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      btarb_pkg::S_IDLE:   if (accept) state_d = btarb_pkg::S_SCAN;
      btarb_pkg::S_SCAN:   if (last) state_d = btarb_pkg::S_FINISH;
      btarb_pkg::S_FINISH: if (fin_fire) state_d = btarb_pkg::S_IDLE;
      default:             state_d = btarb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    scan_en    = 1'b0;
    unique case (state_q)
      btarb_pkg::S_IDLE:   in_ready_o = 1'b1;
      btarb_pkg::S_SCAN:   scan_en = 1'b1;
      btarb_pkg::S_FINISH: ;
      default:             ;
    endcase
  end

  always_comb begin
    max_d      = max_q;
    found_d    = found_q;
    best_d     = best_q;
    best_tkt_d = best_tkt_q;
    idwait_d   = idwait_q;
    if (accept) begin
      max_d    = '0;
      found_d  = 1'b0;
      idwait_d = 1'b0;
    end else if (scan_en) begin
      if (head.ticket > max_q) begin
        max_d = head.ticket;
      end
      if (head.waiting && (!found_q || head.ticket < best_tkt_q)) begin
        found_d    = 1'b1;
        best_d     = cnt_q;
        best_tkt_d = head.ticket;
      end
      if (32'(cnt_q) == 32'(id_q)) begin
        idwait_d = head.waiting;
      end
    end
  end

  assign in_range  = 32'(id_q) < 32'(btarb_pkg::THREADS);
  assign is_holder = holder_v_q && (32'(holder_q) == 32'(id_q));

  always_comb begin
    btarb_pkg::status_e st;
    logic               granted;
    st         = btarb_pkg::STAT_OK;
    granted    = 1'b0;
    holder_v_d = holder_v_q;
    holder_d   = holder_q;
    wr         = '0;
    wr.tkt_idx = IW'(id_q);
    wr.tkt_val = max_q + TB'(1);
    if (cmd_q == btarb_pkg::CMD_REQ) begin
      if (in_range) begin
        if (idwait_q || is_holder) begin
          st = btarb_pkg::STAT_DUP;
        end else if (max_q == '1) begin
          st = btarb_pkg::STAT_SAT;
        end else begin
          wr.tkt_en   = fin_fire;
          wr.wait_idx = IW'(id_q);
          if (holder_v_q) begin
            wr.wait_en  = fin_fire;
            wr.wait_val = 1'b1;
          end else begin
            holder_v_d = 1'b1;
            holder_d   = IW'(id_q);
            granted    = 1'b1;
          end
        end
      end
    end else begin
      if (is_holder && in_range) begin
        wr.tkt_en   = fin_fire;
        wr.tkt_val  = '0;
        holder_v_d  = found_q;
        holder_d    = found_q ? best_q : '0;
        granted     = found_q;
        wr.wait_en  = fin_fire && found_q;
        wr.wait_idx = best_q;
        wr.wait_val = 1'b0;
      end else begin
        st = btarb_pkg::STAT_NOT_HOLDER;
      end
    end
    out_d.grant_valid  = granted;
    out_d.grant_thread = holder_v_d ? btarb_pkg::ID_W'(holder_d) : '0;
    out_d.lock_busy    = holder_v_d;
    out_d.status       = st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= btarb_pkg::S_IDLE;
      cnt_q       <= '0;
      holder_v_q  <= 1'b0;
      holder_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= '0;
      end else if (scan_en) begin
        cnt_q <= last ? '0 : cnt_q + IW'(1);
      end
      if (fin_fire) begin
        holder_v_q  <= holder_v_d;
        holder_q    <= holder_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_item_i.command;
      id_q  <= in_item_i.src_id;
    end
    max_q      <= max_d;
    found_q    <= found_d;
    best_q     <= best_d;
    best_tkt_q <= best_tkt_d;
    idwait_q   <= idwait_d;
    if (fin_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> rtl/core/btarb_checker.sv
// Port-level checker for the bakery ticket arbiter and its bind statement.
module btarb_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input btarb_pkg::in_item_t  in_item_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input btarb_pkg::out_item_t out_item_o
);

  logic in_seen;
  assign in_seen = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item changed while stalled");

  a_free_thread: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.lock_busy |-> out_item_o.grant_thread == '0)
    else $error("free lock reports a holder");

  a_grant_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.grant_valid |-> out_item_o.lock_busy &&
      out_item_o.status == btarb_pkg::STAT_OK)
    else $error("grant without busy lock or with error status");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_seen |=> !(out_valid_o && $rose(out_valid_o)))
    else $error("result appeared right after an item was accepted");

endmodule

bind bakery_ticket_arbiter_core btarb_checker u_btarb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_item_i  (in_item_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);

>>> dv/bakery_ticket_arbiter_core_tb.sv
// Self-checking testbench for the bakery ticket arbiter core with its own lock predictor.
module bakery_ticket_arbiter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 50;
  localparam int RANDOM_ITEMS = 1100;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  btarb_pkg::in_item_t  in_item_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  btarb_pkg::out_item_t out_item_o;

  logic [btarb_pkg::TICKET_BITS-1:0] tkt [btarb_pkg::THREADS];
  logic                              queued [btarb_pkg::THREADS];
  logic                              owner_busy;
  logic [btarb_pkg::ID_W-1:0]        owner_id;

  btarb_pkg::out_item_t lock_results_q [$];

  logic no_gaps = 1'b0;
  int   idle_cycles = 0;
  int   mismatches = 0;
  int   items_in = 0;
  int   results_out = 0;
  int   grants_seen = 0;
  int   status_seen [4] = '{0, 0, 0, 0};
  logic [btarb_pkg::TICKET_BITS-1:0] peak_ticket = '0;

  bakery_ticket_arbiter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= no_gaps || ($urandom_range(99) >= 37);
  end

  function automatic logic [btarb_pkg::TICKET_BITS-1:0] top_ticket();
    logic [btarb_pkg::TICKET_BITS-1:0] top;
    top = '0;
    for (int i = 0; i < btarb_pkg::THREADS; i++) begin
      if (tkt[i] > top) top = tkt[i];
    end
    return top;
  endfunction

  function automatic btarb_pkg::out_item_t predict_lock_result(
    btarb_pkg::cmd_e c, logic [btarb_pkg::ID_W-1:0] id);
    btarb_pkg::out_item_t              res;
    logic [btarb_pkg::TICKET_BITS-1:0] top;
    int                                pick;
    logic                              found;
    res = '0;
    res.status = btarb_pkg::STAT_OK;
    if (c == btarb_pkg::CMD_REQ) begin
      if (queued[id] || (owner_busy && owner_id == id)) begin
        res.status = btarb_pkg::STAT_DUP;
      end else begin
        top = top_ticket();
        if (top == '1) begin
          res.status = btarb_pkg::STAT_SAT;
        end else begin
          tkt[id] = top + 1'b1;
          if (tkt[id] > peak_ticket) peak_ticket = tkt[id];
          if (!owner_busy) begin
            owner_busy = 1'b1;
            owner_id = id;
            res.grant_valid = 1'b1;
          end else begin
            queued[id] = 1'b1;
          end
        end
      end
    end else if (owner_busy && owner_id == id) begin
      tkt[id] = '0;
      owner_busy = 1'b0;
      owner_id = '0;
      found = 1'b0;
      pick = 0;
      for (int i = 0; i < btarb_pkg::THREADS; i++) begin
        if (queued[i] && (!found || tkt[i] < tkt[pick])) begin
          pick = i;
          found = 1'b1;
        end
      end
      if (found) begin
        queued[pick] = 1'b0;
        owner_busy = 1'b1;
        owner_id = pick[btarb_pkg::ID_W-1:0];
        res.grant_valid = 1'b1;
      end
    end else begin
      res.status = btarb_pkg::STAT_NOT_HOLDER;
    end
    res.lock_busy = owner_busy;
    res.grant_thread = owner_busy ? owner_id : '0;
    return res;
  endfunction

  always @(posedge clk_i) begin
    btarb_pkg::out_item_t want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (in_valid_i && in_ready_o) items_in++;
      if (out_valid_o && out_ready_i) begin
        results_out++;
        if (lock_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display({"ERROR: result with nothing expected: ",
                      "grant=%0b thread=%0d busy=%0b status=%0d"},
                     out_item_o.grant_valid, out_item_o.grant_thread,
                     out_item_o.lock_busy, out_item_o.status);
          end
        end else begin
          want = lock_results_q.pop_front();
          if (want.grant_valid) grants_seen++;
          status_seen[want.status]++;
          if (out_item_o.grant_valid !== want.grant_valid ||
              out_item_o.grant_thread !== want.grant_thread ||
              out_item_o.lock_busy !== want.lock_busy ||
              out_item_o.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display({"ERROR: result %0d: expected grant=%0b thread=%0d busy=%0b ",
                        "status=%0d, got grant=%0b thread=%0d busy=%0b status=%0d"},
                       results_out, want.grant_valid, want.grant_thread, want.lock_busy,
                       want.status, out_item_o.grant_valid, out_item_o.grant_thread,
                       out_item_o.lock_busy, out_item_o.status);
            end
          end
        end
      end
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("ERROR: no item moved for %0d cycles", STALL_LIMIT);
    $display("bakery_ticket_arbiter_core_tb NOT OK");
    $finish;
  end

  task automatic issue_command(btarb_pkg::cmd_e c, logic [btarb_pkg::ID_W-1:0] id);
    btarb_pkg::in_item_t item;
    item.command = c;
    item.src_id = id;
    @(negedge clk_i);
    while (!no_gaps && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    lock_results_q.push_back(predict_lock_result(c, id));
    in_item_i <= item;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (lock_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic drain_lock();
    while (owner_busy) issue_command(btarb_pkg::CMD_REL, owner_id);
  endtask

  task automatic test_basic_handoff();
    issue_command(btarb_pkg::CMD_REL, 5'd0);
    issue_command(btarb_pkg::CMD_REQ, 5'd0);
    issue_command(btarb_pkg::CMD_REQ, 5'd0);
    issue_command(btarb_pkg::CMD_REQ, 5'd31);
    issue_command(btarb_pkg::CMD_REQ, 5'd31);
    issue_command(btarb_pkg::CMD_REL, 5'd31);
    issue_command(btarb_pkg::CMD_REQ, 5'd5);
    issue_command(btarb_pkg::CMD_REQ, 5'd10);
    issue_command(btarb_pkg::CMD_REL, 5'd0);
    issue_command(btarb_pkg::CMD_REQ, 5'd0);
    issue_command(btarb_pkg::CMD_REL, 5'd31);
    issue_command(btarb_pkg::CMD_REL, 5'd5);
    issue_command(btarb_pkg::CMD_REL, 5'd10);
    issue_command(btarb_pkg::CMD_REL, 5'd0);
    issue_command(btarb_pkg::CMD_REL, 5'd0);
    issue_command(btarb_pkg::CMD_REQ, 5'd31);
    issue_command(btarb_pkg::CMD_REQ, 5'd21);
    issue_command(btarb_pkg::CMD_REL, 5'd21);
    issue_command(btarb_pkg::CMD_REL, 5'd31);
    issue_command(btarb_pkg::CMD_REL, 5'd21);
  endtask

  task automatic test_random_traffic();
    int                         r;
    int                         tries;
    logic [btarb_pkg::ID_W-1:0] id;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_gaps = (n >= 500 && n < 700);
      if (n == 300) pause_until_drained();
      if (n % 250 == 249) drain_lock();
      r = $urandom_range(99);
      if (r < 45) begin
        id = btarb_pkg::ID_W'($urandom_range(btarb_pkg::THREADS - 1));
        tries = 0;
        while (tries < 4 && (queued[id] || (owner_busy && owner_id == id))) begin
          id = btarb_pkg::ID_W'($urandom_range(btarb_pkg::THREADS - 1));
          tries++;
        end
        issue_command(btarb_pkg::CMD_REQ, id);
      end else if (r < 80 && owner_busy) begin
        issue_command(btarb_pkg::CMD_REL, owner_id);
      end else begin
        issue_command(btarb_pkg::cmd_e'($urandom_range(1)),
                      btarb_pkg::ID_W'($urandom_range(btarb_pkg::THREADS - 1)));
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_full_queue();
    drain_lock();
    no_gaps = 1'b1;
    for (int i = 0; i < btarb_pkg::THREADS; i++) begin
      issue_command(btarb_pkg::CMD_REQ, btarb_pkg::ID_W'(btarb_pkg::THREADS - 1 - i));
    end
    issue_command(btarb_pkg::CMD_REQ, 5'd0);
    issue_command(btarb_pkg::CMD_REL, 5'd0);
    drain_lock();
    no_gaps = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < btarb_pkg::THREADS; i++) begin
      tkt[i] = '0;
      queued[i] = 1'b0;
    end
    owner_busy = 1'b0;
    owner_id = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_basic_handoff();
    test_random_traffic();
    test_full_queue();
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Run covered %0d commands and %0d results with %0d grants; largest ticket %0d.",
             items_in, results_out, grants_seen, peak_ticket);
    $display("Status mix: %0d ok, %0d duplicate, %0d non-holder release, %0d saturated.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (mismatches == 0 && lock_results_q.size() == 0) begin
      $display("bakery_ticket_arbiter_core_tb OK");
    end else begin
      $display("ERROR: %0d mismatches, %0d results still expected", mismatches,
               lock_results_q.size());
      $display("bakery_ticket_arbiter_core_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/btarb_pkg.sv
rtl/core/btarb_cell.sv
rtl/core/btarb_ring.sv
rtl/core/bakery_ticket_arbiter_core.sv
rtl/core/btarb_checker.sv
dv/bakery_ticket_arbiter_core_tb.sv
